@@ hdl/mtwg_pkg.sv @@
// Shared types, constants and word functions of the Mersenne Twister word generator.
package mtwg_pkg;

   localparam int STATE_WORDS   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int WORD_W        = 32;
   localparam int ADDR_W        = $clog2(STATE_WORDS);
   localparam int INDEX_W       = 10;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [INDEX_W-1:0] index_type;

   localparam logic MODE_RESEED = 1'b0;

   localparam word_type HI_BIT       = 32'h8000_0000;
   localparam word_type LO_BITS      = 32'h7fff_ffff;
   localparam word_type TWIST_XOR    = 32'h9908_b0df;
   localparam word_type TEMPER_B     = 32'h9d2c_5680;
   localparam word_type TEMPER_C     = 32'hefc6_0000;
   localparam word_type SEED_MULT    = 32'd6069;
   localparam word_type DEFAULT_SEED = 32'd4357;

   localparam index_type INDEX_FULL     = index_type'(STATE_WORDS);
   localparam index_type INDEX_UNSEEDED = index_type'(STATE_WORDS + 1);
   localparam addr_type  ADDR_LAST      = addr_type'(STATE_WORDS - 1);

   // Status of the seeding sweep as seen by the sequencer.
   typedef struct packed {
      logic     busy;
      logic     done;
      addr_type addr;
      word_type data;
   } seed_stat_type;

   function automatic addr_type next_addr(addr_type k);
      return (k == ADDR_LAST) ? '0 : addr_type'(k + addr_type'(1));
   endfunction

   function automatic addr_type mid_addr(addr_type k);
      logic [ADDR_W:0] sum;
      sum = {1'b0, k} + (ADDR_W+1)'(MIDDLE_OFFSET);
      if (sum >= (ADDR_W+1)'(STATE_WORDS)) begin
         sum = sum - (ADDR_W+1)'(STATE_WORDS);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // y holds the high bit of word k and the low bits of word k+1.
   function automatic word_type twist_word(word_type y, word_type mid);
      word_type w;
      w = mid ^ (y >> 1);
      if (y[0]) begin
         w = w ^ TWIST_XOR;
      end
      return w;
   endfunction

   function automatic word_type temper(word_type v);
      word_type y;
      y = v ^ (v >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ hdl/mtwg_req_if.sv @@
// Request channel: reseed or draw commands with valid/ready handshake.
interface mtwg_req_if;
   import mtwg_pkg::*;

   logic     valid;
   logic     ready;
   logic     mode;
   word_type seed;

   modport source (output valid, output mode, output seed, input ready);
   modport sink (input valid, input mode, input seed, output ready);
endinterface

@@ hdl/mtwg_rsp_if.sv @@
// Response channel: tempered random words with valid/ready handshake.
interface mtwg_rsp_if;
   import mtwg_pkg::*;

   logic     valid;
   logic     ready;
   word_type random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

@@ hdl/mtwg_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module mtwg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

@@ hdl/mtwg_seeder.sv @@
// Seeding sweep: writes seed, seed*6069, ... into every state word, one per cycle.
module mtwg_seeder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mtwg_pkg::word_type      seed,
   output mtwg_pkg::seed_stat_type stat
);
   import mtwg_pkg::*;

   logic     busy_ff, busy_in;
   addr_type cnt_ff, cnt_in;
   word_type val_ff, val_in;
   logic     last;

   assign last = busy_ff && (cnt_ff == ADDR_LAST);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = seed;
      end else if (busy_ff) begin
         cnt_in = addr_type'(cnt_ff + addr_type'(1));
         val_in = word_type'(val_ff * SEED_MULT);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = last;
   assign stat.addr = cnt_ff;
   assign stat.data = val_ff;
endmodule

@@ hdl/mersenne_twister_word_generator.sv @@
// Top level of the Mersenne Twister (MT19937) 32-bit word generator.
// Requests arrive on req_bus: mode 0 reseeds the 624-word store from seed,
// mode 1 draws one tempered word, returned as one beat on rsp_bus.
// A reseed produces no response and occupies the block while the seeding
// sweep writes one state word per cycle.
// A draw twists its state word on the fly from three store reads (word k,
// word k+1 and the word 397 places ahead) on the two read ports, writes the
// new word back and tempers it. Reads run in two rounds on the dual-read-port
// store: the request beat reads words k and k+1, the MID step the middle word;
// the CALC step registers the response, and then a new request is taken.
// After reset the generator is unseeded; the first draw first seeds the store
// with 4357 before it draws word 0.
// The response sits in an output register; the next request is accepted while
// it waits, and only the write-back of the following draw stalls until the
// receiver takes the pending beat.
// Reset is synchronous and clears the control state only; the store is not
// cleared.
module mersenne_twister_word_generator (
   input logic       clock,
   input logic       reset,
   mtwg_req_if.sink  req_bus,
   mtwg_rsp_if.source rsp_bus
);
   import mtwg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_MID   = 3'd3;
   localparam logic [2:0] ST_CALC  = 3'd4;

   logic [2:0] state_ff, state_in;
   index_type  idx_ff, idx_in;
   addr_type   k_ff, k_in;
   word_type   y_ff, y_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_word_ff, rsp_word_in;

   logic          seed_start;
   word_type      seed_value;
   seed_stat_type seed_stat;

   logic     wr_en;
   addr_type wr_addr;
   word_type wr_data;
   logic     rd_en_a, rd_en_b;
   addr_type rd_addr_a, rd_addr_b;
   word_type rd_data_a, rd_data_b;
   logic     twist_we;
   word_type new_word;
   logic     req_beat;

   mtwg_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .start (seed_start),
      .seed  (seed_value),
      .stat  (seed_stat)
   );

   mtwg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STATE_WORDS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_en_b   (rd_en_b),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign new_word      = twist_word(y_ff, rd_data_b);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      y_in         = y_ff;
      pend_in      = pend_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      seed_start   = 1'b0;
      seed_value   = req_bus.seed;
      rd_en_a      = 1'b0;
      rd_en_b      = 1'b0;
      rd_addr_a    = k_ff;
      twist_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_bus.mode == MODE_RESEED) begin
                  seed_start = 1'b1;
                  pend_in    = 1'b0;
                  state_in   = ST_FILL;
               end else if (idx_ff > INDEX_FULL) begin
                  // Unseeded: seed with the default value, then draw word 0.
                  seed_start = 1'b1;
                  seed_value = DEFAULT_SEED;
                  pend_in    = 1'b1;
                  state_in   = ST_FILL;
               end else begin
                  rd_addr_a = (idx_ff == INDEX_FULL) ? '0 : idx_ff[ADDR_W-1:0];
                  k_in      = rd_addr_a;
                  rd_en_a   = 1'b1;
                  rd_en_b   = 1'b1;
                  state_in  = ST_MID;
               end
            end
         end
         ST_FILL: begin
            if (seed_stat.done) begin
               if (pend_ff) begin
                  k_in     = '0;
                  state_in = ST_ISSUE;
               end else begin
                  idx_in   = INDEX_FULL;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ISSUE: begin
            rd_en_a  = 1'b1;
            rd_en_b  = 1'b1;
            state_in = ST_MID;
         end
         ST_MID: begin
            y_in     = (rd_data_a & HI_BIT) | (rd_data_b & LO_BITS);
            rd_en_b  = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               twist_we     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_word_in  = temper(new_word);
               idx_in       = index_type'(k_ff) + index_type'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rd_addr_b = (state_ff == ST_MID) ? mid_addr(k_ff) : next_addr(rd_addr_a);
   end

   assign wr_en   = seed_stat.busy || twist_we;
   assign wr_addr = seed_stat.busy ? seed_stat.addr : k_ff;
   assign wr_data = seed_stat.busy ? seed_stat.data : new_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= INDEX_UNSEEDED;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      y_ff        <= y_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.random_word = rsp_word_ff;

   // A write and a read of the same store entry never fall in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en_a && (wr_addr == rd_addr_a)) &&
      !(wr_en && rd_en_b && (wr_addr == rd_addr_b)))
      else $error("store write collides with a read of the same entry");

   // A new response beat only comes out of the write-back step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CALC)
      else $error("response raised outside the write-back step");

   // The word index never runs past the unseeded mark.
   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= INDEX_UNSEEDED)
      else $error("word index out of range");

   // The seeding sweep only runs while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      seed_stat.busy |-> state_ff == ST_FILL)
      else $error("seeding sweep active outside the fill step");
endmodule

@@ tb/tb_mersenne_twister_word_generator.sv @@
// Self-checking testbench for the MT19937 word generator: directed table, a long run of draws, then random beats.
`timescale 1ns / 1ps

module tb_mersenne_twister_word_generator;
   import mtwg_pkg::*;

   localparam logic MODE_DRAW = 1'b1;
   localparam int   PLAN_LEN  = 22;
   localparam int   IDLE_PCT  = 18;

   typedef struct packed {
      logic     mode;
      word_type seed;
      logic     typed;
      word_type typed_word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtwg_req_if req_bus ();
   mtwg_rsp_if rsp_bus ();

   mersenne_twister_word_generator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Local copy of the generator: word store and read position (625 = unseeded).
   word_type    gen_store [STATE_WORDS];
   int unsigned gen_index = STATE_WORDS + 1;

   word_type    pending_words [$];
   int unsigned mismatch_count = 0;
   bit          steady = 1'b0;
   logic        typed_pending = 1'b0;
   word_type    typed_value = '0;

   // Draws with a typed result: a zero seed leaves the store at zero through every twist.
   stim_row_type plan [PLAN_LEN] = '{
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_DRAW,   32'hffff_ffff, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h1234_5678, 1'b0, 32'h0},
      '{MODE_RESEED, 32'h0000_0000, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b1, 32'h0},
      '{MODE_DRAW,   32'hffff_ffff, 1'b1, 32'h0},
      '{MODE_RESEED, 32'hffff_ffff, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_RESEED, 32'h0000_0001, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_RESEED, 32'h8000_0000, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_RESEED, 32'h7fff_ffff, 1'b0, 32'h0},
      '{MODE_RESEED, 32'haaaa_aaaa, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h5555_5555, 1'b0, 32'h0},
      '{MODE_RESEED, 32'h5555_5555, 1'b0, 32'h0},
      '{MODE_DRAW,   32'haaaa_aaaa, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_RESEED, DEFAULT_SEED,  1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{MODE_DRAW,   32'h0000_0000, 1'b0, 32'h0}
   };

   function automatic void fill_store(word_type s);
      gen_store[0] = s;
      for (int i = 1; i < STATE_WORDS; i++) begin
         gen_store[i] = gen_store[i-1] * SEED_MULT;
      end
      gen_index = STATE_WORDS;
   endfunction

   function automatic void twist_store();
      word_type mix;
      for (int k = 0; k < STATE_WORDS; k++) begin
         mix = {gen_store[k][31], gen_store[(k + 1) % STATE_WORDS][30:0]};
         gen_store[k] = gen_store[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ (mix >> 1)
                        ^ (mix[0] ? TWIST_XOR : word_type'(0));
      end
      gen_index = 0;
   endfunction

   function automatic word_type temper_word(word_type v);
      word_type t;
      t = v ^ (v >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      return t ^ (t >> 18);
   endfunction

   function automatic word_type draw_word();
      word_type picked;
      if (gen_index >= STATE_WORDS) begin
         if (gen_index > STATE_WORDS) begin
            fill_store(DEFAULT_SEED);
         end
         twist_store();
      end
      picked = gen_store[gen_index];
      gen_index = gen_index + 1;
      return temper_word(picked);
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_mersenne_twister_word_generator failed");
      $finish;
   end

   // Receiver: random back-pressure on the response channel.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Both channels are sampled here, so predictions and checks follow beat order.
   always @(posedge clock) begin : check_beats
      word_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.mode == MODE_RESEED) begin
               fill_store(req_bus.seed);
            end else begin
               want = draw_word();
               pending_words.push_back(typed_pending ? typed_value : want);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat, expected none, actual %08h",
                        $time, rsp_bus.random_word);
            end else begin
               want = pending_words.pop_front();
               if (rsp_bus.random_word !== want) begin
                  mismatch_count++;
                  $display("%0t: random_word mismatch, expected %08h, actual %08h",
                           $time, want, rsp_bus.random_word);
               end
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic m, input word_type s);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= m;
      req_bus.seed  <= s;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   initial begin : drive_requests
      logic     m;
      word_type s;
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_RESEED;
      req_bus.seed  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         typed_pending = plan[i].typed;
         typed_value   = plan[i].typed_word;
         send_beat(plan[i].mode, plan[i].seed);
      end
      typed_pending = 1'b0;

      // Hold the request side until every outstanding word has come back.
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_words.size() != 0) begin
         @(negedge clock);
      end

      // A long run of draws from one seed goes well past the point where the
      // middle word of a twist is one that was already twisted.
      send_beat(MODE_RESEED, $urandom);
      steady <= 1'b1;
      for (int i = 0; i < 330; i++) begin
         if (i == 150) begin
            steady <= 1'b0;
         end
         send_beat(MODE_DRAW, $urandom);
      end

      for (int i = 0; i < 100; i++) begin
         m = ($urandom_range(99) < 4) ? MODE_RESEED : MODE_DRAW;
         case ($urandom_range(9))
            0: s = '0;
            1: s = '1;
            default: s = $urandom;
         endcase
         send_beat(m, s);
      end

      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      // A reseed still in progress occupies the block until its seeding sweep ends.
      repeat (700) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_mersenne_twister_word_generator passed");
      end else begin
         $display("tb_mersenne_twister_word_generator failed");
      end
      $finish;
   end

endmodule

@@ mersenne_twister_word_generator.f @@
hdl/mtwg_pkg.sv
hdl/mtwg_req_if.sv
hdl/mtwg_rsp_if.sv
hdl/mtwg_ram.sv
hdl/mtwg_seeder.sv
hdl/mersenne_twister_word_generator.sv
tb/tb_mersenne_twister_word_generator.sv
